// ===== hdl/hepq_pkg.sv =====
// shared types and constants for the half-plane enclosing box query
`timescale 1ns / 1ps
package hepq_pkg;

  localparam int CoefW  = 16;
  localparam int CoordW = 32;
  localparam int AreaW  = 48;

  typedef enum logic [1:0] {
    CLS_XHI = 2'd0,
    CLS_XLO = 2'd1,
    CLS_YLO = 2'd2,
    CLS_YHI = 2'd3
  } hepq_cls_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_QUERY  = 1'b1
  } hepq_mode_t;

  typedef struct packed {
    logic                     vld;
    logic                     last;
    hepq_cls_t                cls;
    logic signed [CoordW-1:0] val;
  } hepq_ent_t;

endpackage

// ===== hdl/hepq_div.sv =====
// iterative restoring divider for boundary computation with saturation
`timescale 1ns / 1ps
module hepq_div
  import hepq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CoordW-1:0]        num_mag,
  input  logic [CoefW-1:0]         den_mag,
  input  logic                     neg,
  output logic                     done,
  output logic signed [CoordW-1:0] quot
);

  localparam int CntW = $clog2(CoordW) + 1;

  logic              busy;
  logic [CntW-1:0]   cnt;
  logic [CoefW-1:0]  rem;
  logic [CoordW-1:0] quo;
  logic [CoefW-1:0]  den;
  logic              sgn;
  logic [CoefW:0]    rem_s;
  logic              fits;

  assign rem_s = {rem, quo[CoordW-1]};
  assign fits  = rem_s >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(CoordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num_mag;
      den <= den_mag;
      sgn <= neg;
    end else if (busy) begin
      rem <= fits ? CoefW'(rem_s - {1'b0, den}) : rem_s[CoefW-1:0];
      quo <= {quo[CoordW-2:0], fits};
    end
  end

  always_comb begin
    if (sgn) begin
      quot = -$signed(quo);
    end else if (quo[CoordW-1]) begin
      quot = {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      quot = $signed(quo);
    end
  end

endmodule

// ===== hdl/hepq_cell.sv =====
// one tracking cell of the scan chain, keeps the nearest boundary of its class
`timescale 1ns / 1ps
module hepq_cell
  import hepq_pkg::*;
#(
  parameter hepq_cls_t CLS     = CLS_XHI,
  parameter bit        GREATER = 1'b1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic signed [CoordW-1:0] pt,
  input  hepq_ent_t                ent_in,
  output hepq_ent_t                ent_out,
  output logic signed [CoordW-1:0] best,
  output logic                     found
);

  logic beyond;
  logic nearer;
  logic take;

  assign beyond = GREATER ? (ent_in.val > pt) : (ent_in.val < pt);
  assign nearer = GREATER ? (ent_in.val < best) : (ent_in.val > best);
  assign take   = ent_in.vld && (ent_in.cls == CLS) && beyond && (!found || nearer);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found       <= 1'b0;
      ent_out.vld <= 1'b0;
    end else begin
      ent_out.vld <= ent_in.vld;
      if (take) begin
        found <= 1'b1;
      end
    end
    ent_out.last <= ent_in.last;
    ent_out.cls  <= ent_in.cls;
    ent_out.val  <= ent_in.val;
    if (take) begin
      best <= ent_in.val;
    end
  end

endmodule

// ===== hdl/axis_halfplane_enclosing_box_query.sv =====
// top level: boundary table, divider, scan chain and area output
//
// slave stream carries inserts (tuser = 0) and queries (tuser = 1); the
// master stream returns one word per query, none per insert.
// an insert runs the serial divider that forms the boundary, then a
// table write. a query reads the boundary memory one entry per cycle
// and pushes each entry down a chain of four class cells, then forms
// the area product and offers its result word.
// a new word is accepted once the previous item is done, even while the
// last result still waits on the master side; a query that finishes
// while the master is stalled waits until the previous result is taken.
// inserts with both coefficients zero or into a full table are dropped.
// reset clears the entry count and all control; table contents stay
// undefined but are never read before they are written.
`timescale 1ns / 1ps
module axis_halfplane_enclosing_box_query
  import hepq_pkg::*;
#(
  parameter int MAX_LINES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // coef_a, coef_b, coef_c, point_x, point_y
  input  logic         s_tuser,  // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata,  // area
  output logic         m_tuser   // inside_res
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SCAN = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [AW-1:0] idx;
  logic          rd_issue;

  logic signed [CoefW-1:0]  coef_a, coef_b, coef_c;
  logic signed [CoordW-1:0] point_x, point_y;
  logic signed [CoordW-1:0] px, py;

  logic              in_acc;
  logic              div_start, div_done;
  logic signed [CoefW-1:0] dsel;
  logic [CoordW-1:0] num_mag;
  logic [CoefW-1:0]  den_mag;
  logic              neg;
  logic signed [CoordW-1:0] quot;
  hepq_cls_t         ins_cls;

  logic [CoordW+1:0] mem [MAX_LINES];
  logic [CoordW+1:0] rd_data;
  logic              rd_vld, rd_last, issue_last;

  hepq_ent_t ent [5];
  logic signed [CoordW-1:0] best [4];
  logic [3:0]  found;
  logic        clear;
  logic        scan_done;
  logic [63:0] prod;

  assign coef_a  = s_tdata[15:0];
  assign coef_b  = s_tdata[31:16];
  assign coef_c  = s_tdata[47:32];
  assign point_x = s_tdata[79:48];
  assign point_y = s_tdata[111:80];

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign dsel    = (coef_a != '0) ? coef_a : coef_b;
  assign num_mag = {(coef_c[CoefW-1] ? CoefW'(-coef_c) : coef_c), {CoefW{1'b0}}};
  assign den_mag = dsel[CoefW-1] ? CoefW'(-dsel) : dsel;
  assign neg     = (coef_c > 0) ^ dsel[CoefW-1];
  assign div_start = in_acc && (s_tuser == MODE_INSERT) &&
                     ((coef_a != '0) || (coef_b != '0)) && (count != CW'(MAX_LINES));

  hepq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num_mag (num_mag),
    .den_mag (den_mag),
    .neg     (neg),
    .done    (div_done),
    .quot    (quot)
  );

  assign clear      = in_acc && (s_tuser == MODE_QUERY);
  assign rd_issue   = (state == S_SCAN) && (count != '0) && !issue_last;
  assign scan_done  = ent[4].vld && ent[4].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      issue_last <= 1'b0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (div_start) begin
            state <= S_DIV;
          end else if (clear) begin
            state      <= S_SCAN;
            idx        <= '0;
            issue_last <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            count <= count + 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (count == '0) begin
            state <= S_MUL;
          end else begin
            if (rd_issue) begin
              idx <= idx + 1'b1;
              if ({1'b0, idx} == count - 1'b1) begin
                issue_last <= 1'b1;
              end
            end
            if (scan_done) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (coef_a != '0) begin
      ins_cls = coef_a[CoefW-1] ? CLS_XLO : CLS_XHI;
    end else begin
      ins_cls = coef_b[CoefW-1] ? CLS_YLO : CLS_YHI;
    end
  end

  hepq_cls_t pend_cls;

  always_ff @(posedge clk) begin
    if (div_start) begin
      pend_cls <= ins_cls;
    end
    if (clear) begin
      px <= point_x;
      py <= point_y;
    end
    if (state == S_DIV && div_done) begin
      mem[count[AW-1:0]] <= {pend_cls, quot};
    end
    if (rd_issue) begin
      rd_data <= mem[idx];
      rd_last <= ({1'b0, idx} == count - 1'b1);
    end
  end

  assign ent[0].vld  = rd_vld;
  assign ent[0].last = rd_last;
  assign ent[0].cls  = hepq_cls_t'(rd_data[CoordW+1:CoordW]);
  assign ent[0].val  = rd_data[CoordW-1:0];

  localparam hepq_cls_t CellCls [4] = '{CLS_XHI, CLS_XLO, CLS_YLO, CLS_YHI};
  localparam bit        CellGt  [4] = '{1'b1, 1'b0, 1'b0, 1'b1};

  for (genvar g = 0; g < 4; g++) begin : g_cell
    hepq_cell #(
      .CLS     (CellCls[g]),
      .GREATER (CellGt[g])
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .pt      ((g < 2) ? px : py),
      .ent_in  (ent[g]),
      .ent_out (ent[g+1]),
      .best    (best[g]),
      .found   (found[g])
    );
  end

  logic [CoordW-1:0] wid, hgt;
  assign wid = CoordW'(best[0] - best[1]);
  assign hgt = CoordW'(best[3] - best[2]);

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= wid * hgt;
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= &found;
      m_tdata <= (&found) ? prod[63:16] : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_LINES))
    else $error("entry count beyond table depth");
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("area nonzero on miss");
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider finished outside insert");
  assert property (@(posedge clk) disable iff (rst) rd_issue |-> ({1'b0, idx} < count))
    else $error("read of unwritten entry");

endmodule

// ===== tb/sv/axis_halfplane_enclosing_box_query_tb.sv =====
// testbench: random and directed inserts and queries checked against a box predictor
`timescale 1ns / 1ps
module axis_halfplane_enclosing_box_query_tb;
  import hepq_pkg::*;

  localparam int Lines = 1024;
  localparam longint CycleLimit = 4000000;

  typedef struct {
    logic        hit;
    logic [47:0] area;
  } box_res_t;

  class box_scoreboard;
    logic signed [31:0] bnd[Lines];
    hepq_cls_t          cls[Lines];
    int                 count;
    box_res_t           pending[$];
    int                 errors;

    function void clear();
      count = 0;
      errors = 0;
      pending.delete();
    endfunction

    function logic signed [31:0] edge_of(longint c, longint d);
      longint q;
      q = (-c * 65536) / d;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
    endfunction

    function void note_item(hepq_mode_t mode, logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c, logic signed [31:0] px,
                            logic signed [31:0] py);
      longint xh, xl, yl, yh, v;
      bit fxh, fxl, fyl, fyh;
      box_res_t r;
      longint unsigned w, h, p;
      if (mode == MODE_INSERT) begin
        if ((a == 0 && b == 0) || count >= Lines) return;
        if (a != 0) begin
          bnd[count] = edge_of(c, a);
          cls[count] = (a > 0) ? CLS_XHI : CLS_XLO;
        end else begin
          bnd[count] = edge_of(c, b);
          cls[count] = (b < 0) ? CLS_YLO : CLS_YHI;
        end
        count++;
        return;
      end
      fxh = 0; fxl = 0; fyl = 0; fyh = 0;
      xh = 0; xl = 0; yl = 0; yh = 0;
      for (int i = 0; i < count; i++) begin
        v = bnd[i];
        case (cls[i])
          CLS_XHI: if (v > px && (!fxh || v < xh)) begin xh = v; fxh = 1; end
          CLS_XLO: if (v < px && (!fxl || v > xl)) begin xl = v; fxl = 1; end
          CLS_YLO: if (v < py && (!fyl || v > yl)) begin yl = v; fyl = 1; end
          default: if (v > py && (!fyh || v < yh)) begin yh = v; fyh = 1; end
        endcase
      end
      if (fxh && fxl && fyl && fyh) begin
        w = xh - xl;
        h = yh - yl;
        p = w * h;
        r.hit = 1;
        r.area = p[63:16];
      end else begin
        r.hit = 0;
        r.area = 0;
      end
      pending = {pending, r};
    endfunction

    function void check_word(logic hit, logic [47:0] area);
      box_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word hit=%0b area=%h", hit, area);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || area !== e.area) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit=%0b area=%h got hit=%0b area=%h",
                   e.hit, e.area, hit, area);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;
  logic         m_tuser;

  box_scoreboard sb;
  int  src_idle;
  int  snk_stall;
  bit  hold_off;
  longint cycles = 0;

  axis_halfplane_enclosing_box_query u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.clear();
  end

  // receiver side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata);
      m_tready <= !hold_off && ($urandom_range(99) >= snk_stall);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(hepq_mode_t mode, logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c, logic signed [31:0] px,
                           logic signed [31:0] py);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= mode;
    s_tdata  <= {py, px, c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(mode, a, b, c, px, py);
  endtask

  task automatic send_insert(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c);
    send_word(MODE_INSERT, a, b, c, $urandom, $urandom);
  endtask

  task automatic send_query(logic signed [31:0] px, logic signed [31:0] py);
    send_word(MODE_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), px, py);
  endtask

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($urandom_range(1, 8));
      4: return 16'(-$signed(17'($urandom_range(1, 8))));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      default: return $signed(32'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    src_idle = idle;
    snk_stall = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) send_query(rand_coord(), rand_coord());
      else if ($urandom_range(3) == 0)
        send_insert(rand_coef(), rand_coef(), rand_coef());
      else begin
        // well-formed small boundaries around the origin
        case ($urandom_range(3))
          0: send_insert(16'($urandom_range(1, 4)), 16'($urandom),
                         16'(-$signed(17'($urandom_range(0, 30)))));
          1: send_insert(16'(-$signed(17'($urandom_range(1, 4)))), 16'($urandom),
                         16'(-$signed(17'($urandom_range(0, 30)))));
          2: send_insert(16'sh0000, 16'($urandom_range(1, 4)),
                         16'(-$signed(17'($urandom_range(0, 30)))));
          default: send_insert(16'sh0000, 16'(-$signed(17'($urandom_range(1, 4)))),
                               16'(-$signed(17'($urandom_range(0, 30)))));
        endcase
      end
    end
  endtask

  initial begin
    int w;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tuser = 0;
    hold_off = 0;
    src_idle = 0;
    snk_stall = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, degenerate, each class, equal boundary, saturation
    send_query(0, 0);
    send_insert(0, 0, 16'sh7fff);
    send_insert(1, 0, -10);
    send_query(0, 0);
    send_insert(-1, 0, -2);
    send_insert(0, -1, -3);
    send_insert(0, 1, -20);
    send_query(32'sh0005_0000, 32'sh0008_0000);
    send_query(32'sh0002_0000, 32'sh0008_0000);
    send_query(32'sh0005_0000, 32'sh0014_0000);
    send_insert(1, 5, 16'sh8000);
    send_insert(-1, 0, 16'sh7fff);
    send_insert(0, 1, 16'sh8000);
    send_insert(0, -1, 16'sh7fff);
    send_insert(16'sh7fff, 0, 1);
    send_insert(16'sh8000, 16'sh7fff, 16'sh8000);
    send_query(32'sh8000_0000, 32'sh7fff_ffff);
    send_query(32'sh7fff_ffff, 32'sh8000_0000);
    send_query(32'sh0005_0000, 32'sh0008_0000);

    // pressure: receiver holds off while queries keep coming
    hold_off = 1;
    fork
      begin
        for (int i = 0; i < 6; i++) send_query(rand_coord(), rand_coord());
        s_tvalid <= 0;
        @(posedge clk);
      end
      begin
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
    join

    random_phase(145, 0, 0);
    random_phase(145, 76, 0);
    random_phase(145, 0, 76);
    random_phase(145, 32, 32);

    s_tvalid <= 0;
    src_idle = 0;
    snk_stall = 0;
    w = 0;
    while (sb.pending.size() != 0 && w < 200000) begin
      @(posedge clk);
      w++;
    end
    repeat (1100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hepq_pkg.sv
hdl/hepq_div.sv
hdl/hepq_cell.sv
hdl/axis_halfplane_enclosing_box_query.sv
tb/sv/axis_halfplane_enclosing_box_query_tb.sv
